>>> hw/rtl/software_timer_table_macros.svh
// Assertion helpers for the checker of the timer table.
`ifndef SOFTWARE_TIMER_TABLE_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SWTT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("timer table check failed: %m");

// Check a property at every clock edge, reset included.
`define SWTT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("timer table check failed: %m");

`endif

>>> hw/rtl/swtt_pkg.sv
package swtt_pkg;

    localparam int SLOT_W  = 4;
    localparam int SLOTS   = 1 << SLOT_W;
    localparam int CNT_W   = SLOT_W + 1;
    localparam int TIME_W  = 40;
    localparam int DELAY_W = 32;
    localparam int TAG_W   = 16;
    localparam int MODE_W  = 2;
    localparam int KIND_W  = 3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Request modes
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Response kinds
    localparam logic [KIND_W-1:0] KIND_FIRED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADDED    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVED  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NOTFOUND = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [DELAY_W-1:0] delay_val;
        logic               periodic;
        logic [TAG_W-1:0]   user_tag;
        logic [SLOT_W-1:0]  handle;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] task_handle;
        logic [TAG_W-1:0]  tag_out;
        logic [TIME_W-1:0] time_now;
        logic              last;
    } rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load_in;
        logic              tick_start;
        logic              rem_start;
        logic              idx_inc;
        logic              sel_last;
        logic              cap_slot;
        logic              fire_step;
        logic              do_add;
        logic              do_remove;
        logic              emit;
        logic [KIND_W-1:0] emit_kind;
        logic              emit_last;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              scan_done;
        logic              fire;
        logic              match;
        logic              full;
        logic              out_free;
        logic              pend_valid;
    } dp_sts_t;

    // Saturating add of a delay to a time value
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] base,
                                                  input logic [DELAY_W-1:0] inc);
        logic [TIME_W:0] sum;
        sum = {1'b0, base} + {{(TIME_W + 1 - DELAY_W){1'b0}}, inc};
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    // Lowest clear bit of the slot-used vector
    function automatic logic [SLOT_W-1:0] first_free(input logic [SLOTS-1:0] used);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> hw/rtl/swtt_ram.sv
module swtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/swtt_dp.sv
module swtt_dp
    import swtt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  req_t    req,
    output rsp_t    rsp,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    input  dp_cmd_t cmd,
    output dp_sts_t sts
);

    req_t              req_reg;
    logic [TIME_W-1:0] time_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              pend_valid_reg;
    logic [SLOT_W-1:0] pend_slot_reg;
    logic [TAG_W-1:0]  pend_tag_reg;
    logic [SLOTS-1:0]  used_reg;
    logic [SLOTS-1:0]  armed_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    logic [CNT_W-1:0]   last_idx;
    logic [SLOT_W-1:0]  free_slot;
    logic [SLOT_W-1:0]  order_rd_addr;
    logic               order_wr_en;
    logic [SLOT_W-1:0]  order_wr_addr;
    logic [SLOT_W-1:0]  order_wr_data;
    logic [SLOT_W-1:0]  order_rd_data;
    logic [SLOT_W-1:0]  slot_rd_addr;
    logic [SLOT_W-1:0]  slot_wr_addr;
    logic               due_wr_en;
    logic [TIME_W-1:0]  due_wr_data;
    logic [TIME_W-1:0]  due_rd_data;
    logic [DELAY_W-1:0] period_wr_data;
    logic [DELAY_W-1:0] period_rd_data;
    logic [TAG_W-1:0]   tag_rd_data;
    logic               out_free;
    logic [SLOT_W-1:0]  emit_handle;
    logic [TAG_W-1:0]   emit_tag;

    assign last_idx  = count_reg - CNT_W'(1);
    assign free_slot = first_free(used_reg);
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Scan order memory: read at the scan index or at the last entry
    assign order_rd_addr = cmd.sel_last ? last_idx[SLOT_W-1:0] : idx_reg[SLOT_W-1:0];
    assign order_wr_en   = cmd.do_add || cmd.do_remove;
    assign order_wr_addr = cmd.do_add ? count_reg[SLOT_W-1:0] : idx_reg[SLOT_W-1:0];
    assign order_wr_data = cmd.do_add ? free_slot : order_rd_data;

    swtt_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_order_ram (
        .clk     (clk),
        .wr_en   (order_wr_en),
        .wr_addr (order_wr_addr),
        .wr_data (order_wr_data),
        .rd_addr (order_rd_addr),
        .rd_data (order_rd_data)
    );

    // Per-slot memories: read at the slot just fetched from the scan order
    assign slot_rd_addr   = cmd.cap_slot ? order_rd_data : slot_reg;
    assign slot_wr_addr   = cmd.do_add ? free_slot : slot_reg;
    assign due_wr_en      = cmd.do_add || (cmd.fire_step && (period_rd_data != '0));
    assign due_wr_data    = cmd.do_add ? sat_add(time_reg, req_reg.delay_val)
                                       : sat_add(time_reg, period_rd_data);
    assign period_wr_data = (req_reg.periodic && (req_reg.delay_val != '0))
                            ? req_reg.delay_val : '0;

    swtt_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_due_ram (
        .clk     (clk),
        .wr_en   (due_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (due_wr_data),
        .rd_addr (slot_rd_addr),
        .rd_data (due_rd_data)
    );

    swtt_ram #(.WIDTH(DELAY_W), .DEPTH(SLOTS)) u_period_ram (
        .clk     (clk),
        .wr_en   (cmd.do_add),
        .wr_addr (slot_wr_addr),
        .wr_data (period_wr_data),
        .rd_addr (slot_rd_addr),
        .rd_data (period_rd_data)
    );

    swtt_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
        .clk     (clk),
        .wr_en   (cmd.do_add),
        .wr_addr (slot_wr_addr),
        .wr_data (req_reg.user_tag),
        .rd_addr (slot_rd_addr),
        .rd_data (tag_rd_data)
    );

    // Pick the handle and tag of the response being issued
    always_comb
    begin
        emit_handle = '0;
        emit_tag    = '0;
        case (cmd.emit_kind)
            KIND_FIRED:
            begin
                emit_handle = pend_slot_reg;
                emit_tag    = pend_tag_reg;
            end
            KIND_ADDED:   emit_handle = free_slot;
            KIND_REMOVED: emit_handle = req_reg.handle;
            default:
            begin
                emit_handle = '0;
                emit_tag    = '0;
            end
        endcase
    end

    // Control registers: counter, indexes, slot flags, response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            idx_reg        <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            used_reg       <= '0;
            armed_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.tick_start)
            begin
                if (time_reg != TIME_MAX)
                begin
                    time_reg <= time_reg + TIME_W'(1);
                end
                idx_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.rem_start)
            begin
                idx_reg <= '0;
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.fire_step)
            begin
                pend_valid_reg <= 1'b1;
                if (period_rd_data == '0)
                begin
                    armed_reg[slot_reg] <= 1'b0;
                end
            end
            if (cmd.do_add)
            begin
                used_reg[free_slot]  <= 1'b1;
                armed_reg[free_slot] <= 1'b1;
                count_reg            <= count_reg + CNT_W'(1);
            end
            if (cmd.do_remove)
            begin
                used_reg[req_reg.handle]  <= 1'b0;
                armed_reg[req_reg.handle] <= 1'b0;
                count_reg                 <= last_idx;
            end
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg <= req;
        end
        if (cmd.cap_slot)
        begin
            slot_reg <= order_rd_data;
        end
        if (cmd.fire_step)
        begin
            pend_slot_reg <= slot_reg;
            pend_tag_reg  <= tag_rd_data;
        end
        if (cmd.emit)
        begin
            rsp_reg.kind        <= cmd.emit_kind;
            rsp_reg.task_handle <= emit_handle;
            rsp_reg.tag_out     <= emit_tag;
            rsp_reg.time_now    <= time_reg;
            rsp_reg.last        <= cmd.emit_last;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // Status to the controller
    assign sts.mode       = req_reg.mode;
    assign sts.scan_done  = (idx_reg == count_reg);
    assign sts.fire       = armed_reg[slot_reg] && (due_rd_data <= time_reg);
    assign sts.match      = (order_rd_data == req_reg.handle);
    assign sts.full       = (&used_reg) || (count_reg >= CNT_W'(SLOTS));
    assign sts.out_free   = out_free;
    assign sts.pend_valid = pend_valid_reg;

endmodule

>>> hw/rtl/swtt_ctrl.sv
module swtt_ctrl
    import swtt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DISPATCH  = 4'd1;
    localparam logic [3:0] ST_SCAN_CHK  = 4'd2;
    localparam logic [3:0] ST_SCAN_SLOT = 4'd3;
    localparam logic [3:0] ST_SCAN_EVAL = 4'd4;
    localparam logic [3:0] ST_TICK_END  = 4'd5;
    localparam logic [3:0] ST_ADD       = 4'd6;
    localparam logic [3:0] ST_REM_CHK   = 4'd7;
    localparam logic [3:0] ST_REM_CMP   = 4'd8;
    localparam logic [3:0] ST_REM_LAST  = 4'd9;
    localparam logic [3:0] ST_REM_WR    = 4'd10;
    localparam logic [3:0] ST_NONE_OUT  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign req_ready = (state_reg == ST_IDLE);

    // Sequence one request: tick scan, add, remove search or no-op
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (sts.mode)
                    MODE_TICK:
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = ST_SCAN_CHK;
                    end
                    MODE_ADD: state_next = ST_ADD;
                    MODE_REMOVE:
                    begin
                        cmd.rem_start = 1'b1;
                        state_next    = ST_REM_CHK;
                    end
                    default: state_next = ST_NONE_OUT;
                endcase
            end
            ST_SCAN_CHK:
            begin
                state_next = sts.scan_done ? ST_TICK_END : ST_SCAN_SLOT;
            end
            ST_SCAN_SLOT:
            begin
                cmd.cap_slot = 1'b1;
                state_next   = ST_SCAN_EVAL;
            end
            ST_SCAN_EVAL:
            begin
                if (!sts.fire)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SCAN_CHK;
                end
                else if (!sts.pend_valid || sts.out_free)
                begin
                    // Release the previous firing, hold this one back
                    cmd.fire_step = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    cmd.emit      = sts.pend_valid;
                    cmd.emit_kind = KIND_FIRED;
                    cmd.emit_last = 1'b0;
                    state_next    = ST_SCAN_CHK;
                end
            end
            ST_TICK_END:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = sts.pend_valid ? KIND_FIRED : KIND_NONE;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_ADD:
            begin
                if (sts.out_free)
                begin
                    cmd.do_add    = !sts.full;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = sts.full ? KIND_FULL : KIND_ADDED;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_REM_CHK:
            begin
                if (!sts.scan_done)
                begin
                    state_next = ST_REM_CMP;
                end
                else if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_NOTFOUND;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_REM_CMP:
            begin
                if (sts.match)
                begin
                    state_next = ST_REM_LAST;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_REM_CHK;
                end
            end
            ST_REM_LAST:
            begin
                cmd.sel_last = 1'b1;
                state_next   = ST_REM_WR;
            end
            ST_REM_WR:
            begin
                cmd.sel_last = 1'b1;
                if (sts.out_free)
                begin
                    cmd.do_remove = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_REMOVED;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_NONE_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_NONE;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/software_timer_table.sv
// Software timer table with sixteen task slots and a 40-bit millisecond counter.
// One request is handled at a time; req_ready is high only between requests, while
// a finished response may still wait in the output register. Every response shows
// the counter value after its request, and last marks the final response of a
// request. An add needs no search, a remove searches the scan order entry by
// entry until the match or the end of the list, and a tick walks all listed
// tasks in scan order. Each entry of a tick takes two dependent registered RAM
// reads, first the scan order and then the slot's due time, period and tag, and
// a due entry waits while the previous fired response cannot yet leave the output
// register. Each fired response is released when the next due task is found or
// at scan end. No clearing pass follows reset: slot memories are read only after
// an add.
module software_timer_table
    import swtt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    swtt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    swtt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> hw/rtl/swtt_checker.sv
`include "software_timer_table_macros.svh"

module swtt_checker
    import swtt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    logic no_task_kind;

    // Kinds that carry no task
    assign no_task_kind = (rsp.kind == KIND_NONE) || (rsp.kind == KIND_FULL)
                          || (rsp.kind == KIND_NOTFOUND);

    // Accepting a request makes the block busy in the next cycle
    `SWTT_ASSERT(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready)

    // A response that is not the last of its request keeps the block busy
    `SWTT_ASSERT(a_nonlast_busy, (rsp_valid && !rsp.last) |-> !req_ready)

    // A stalled response holds its payload
    `SWTT_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))

    // Responses without a task carry zero handle and tag
    `SWTT_ASSERT(a_zero_fields, (rsp_valid && no_task_kind) |-> (rsp.task_handle == '0 && rsp.tag_out == '0))

endmodule

bind software_timer_table swtt_checker u_checker (.*);

>>> tb/software_timer_table_test.sv
`timescale 1ns / 1ps

module software_timer_table_test;
    import swtt_pkg::*;

    localparam int MAX_FIRED  = 16;
    localparam int IDLE_PCT   = 13;
    localparam int TAIL_CYCLES = 20;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    software_timer_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Shadow copy of the timer table
    logic [TIME_W-1:0]  timer_now;
    logic [TIME_W-1:0]  slot_due    [SLOTS];
    logic [DELAY_W-1:0] slot_period [SLOTS];
    logic [TAG_W-1:0]   slot_tag    [SLOTS];
    logic               slot_armed  [SLOTS];
    logic               slot_taken  [SLOTS];
    logic [SLOT_W-1:0]  order_list  [SLOTS];
    int                 order_len;

    rsp_t expected_rsp[$];
    int   mismatch_count;

    // Idle control for both sides, and a long receiver hold-off request
    bit req_idle_on;
    bit rsp_idle_on;
    int rsp_hold_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [TIME_W-1:0] due_after(logic [TIME_W-1:0] base,
                                                    logic [DELAY_W-1:0] inc);
        logic [TIME_W:0] sum;
        sum = {1'b0, base} + {9'b0, inc};
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    function automatic void queue_result(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                         logic [TAG_W-1:0] tag);
        rsp_t item;
        item.kind        = kind;
        item.task_handle = slot;
        item.tag_out     = tag;
        item.time_now    = timer_now;
        item.last        = 1'b0;
        expected_rsp.push_back(item);
    endfunction

    // Update the shadow table for one request and queue its responses
    function automatic void predict_request(req_t r);
        int fired;
        int s;
        bit found;
        fired = 0;
        s = -1;
        found = 1'b0;
        case (r.mode)
            MODE_TICK:
            begin
                if (timer_now != TIME_MAX)
                    timer_now = timer_now + TIME_W'(1);
                for (int i = 0; i < order_len && fired < MAX_FIRED; i++)
                begin
                    s = int'(order_list[i]);
                    if (slot_armed[s] && slot_due[s] <= timer_now)
                    begin
                        queue_result(KIND_FIRED, SLOT_W'(s), slot_tag[s]);
                        fired++;
                        if (slot_period[s] != '0)
                            slot_due[s] = due_after(timer_now, slot_period[s]);
                        else
                            slot_armed[s] = 1'b0;
                    end
                end
                if (fired == 0)
                    queue_result(KIND_NONE, '0, '0);
            end
            MODE_ADD:
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                begin
                    if (!slot_taken[i])
                        s = i;
                end
                if (s < 0 || order_len >= SLOTS)
                begin
                    queue_result(KIND_FULL, '0, '0);
                end
                else
                begin
                    slot_taken[s]  = 1'b1;
                    slot_armed[s]  = 1'b1;
                    slot_tag[s]    = r.user_tag;
                    slot_due[s]    = due_after(timer_now, r.delay_val);
                    slot_period[s] = (r.periodic && r.delay_val != '0) ? r.delay_val : '0;
                    order_list[order_len] = SLOT_W'(s);
                    order_len++;
                    queue_result(KIND_ADDED, SLOT_W'(s), '0);
                end
            end
            MODE_REMOVE:
            begin
                for (int i = 0; i < order_len && !found; i++)
                begin
                    if (order_list[i] == r.handle)
                    begin
                        order_len--;
                        order_list[i] = order_list[order_len];
                        slot_taken[r.handle] = 1'b0;
                        slot_armed[r.handle] = 1'b0;
                        found = 1'b1;
                    end
                end
                if (found)
                    queue_result(KIND_REMOVED, r.handle, '0);
                else
                    queue_result(KIND_NOTFOUND, '0, '0);
            end
            default:
            begin
                queue_result(KIND_NONE, '0, '0);
            end
        endcase
        expected_rsp[expected_rsp.size() - 1].last = 1'b1;
    endfunction

    function automatic req_t make_req(logic [MODE_W-1:0] mode, logic [DELAY_W-1:0] delay,
                                      logic per, logic [TAG_W-1:0] tag,
                                      logic [SLOT_W-1:0] slot);
        req_t r;
        r.mode      = mode;
        r.delay_val = delay;
        r.periodic  = per;
        r.user_tag  = tag;
        r.handle    = slot;
        return r;
    endfunction

    // Mostly short delays so that tasks fire, now and then the full range
    function automatic req_t random_request();
        req_t r;
        int   pick;
        r.delay_val = $urandom;
        r.periodic  = 1'($urandom_range(0, 1));
        r.user_tag  = TAG_W'($urandom);
        r.handle    = SLOT_W'($urandom_range(0, SLOTS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 60)
            r.delay_val = $urandom_range(0, 8);
        else if (pick < 85)
            r.delay_val = $urandom_range(0, 64);
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            r.mode = MODE_TICK;
        end
        else if (pick < 73)
        begin
            r.mode = MODE_ADD;
        end
        else if (pick < 97)
        begin
            r.mode = MODE_REMOVE;
            if (order_len > 0 && $urandom_range(0, 99) < 85)
                r.handle = order_list[$urandom_range(0, order_len - 1)];
        end
        else
        begin
            r.mode = MODE_UNUSED;
        end
        return r;
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_item(req_t item);
        int gap;
        gap = (req_idle_on && $urandom_range(0, 99) < IDLE_PCT) ? $urandom_range(1, 4) : 0;
        @(negedge clk);
        while (gap > 0)
        begin
            req_valid <= 1'b0;
            gap--;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        predict_request(item);
    endtask

    // Drop valid and wait until every expected response has come back
    task automatic wait_drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        // Empty table, unused mode, unknown handle
        send_item(make_req(MODE_TICK, '0, 1'b0, '0, '0));
        send_item(make_req(MODE_UNUSED, '1, 1'b1, '1, '1));
        send_item(make_req(MODE_REMOVE, '0, 1'b0, '0, 4'd15));
        // Periodic with zero delay fires once; a far task never fires
        send_item(make_req(MODE_ADD, '0, 1'b1, 16'hFFFF, '0));
        send_item(make_req(MODE_ADD, 32'd1, 1'b1, 16'hA5A5, '0));
        send_item(make_req(MODE_ADD, '1, 1'b1, '0, '0));
        send_item(make_req(MODE_TICK, '0, 1'b0, '0, '0));
        // Fill the table, then overflow it
        for (int i = 0; i < 13; i++)
            send_item(make_req(MODE_ADD, 32'd1, 1'b1, TAG_W'($urandom), '0));
        send_item(make_req(MODE_ADD, 32'd5, 1'b0, 16'h1234, '0));
        // Fire almost every slot on one tick
        send_item(make_req(MODE_TICK, '0, 1'b0, '0, '0));
        // Remove from the middle, twice, then a disarmed one-shot
        send_item(make_req(MODE_REMOVE, '0, 1'b0, '0, 4'd2));
        send_item(make_req(MODE_REMOVE, '0, 1'b0, '0, 4'd2));
        send_item(make_req(MODE_REMOVE, '0, 1'b0, '0, 4'd0));
        send_item(make_req(MODE_TICK, '0, 1'b0, '0, '0));
        wait_drain();
    endtask

    task automatic test_random_traffic(int count);
        repeat (count) send_item(random_request());
        wait_drain();
    endtask

    task automatic test_back_to_back(int count);
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        repeat (count) send_item(random_request());
        wait_drain();
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
    endtask

    // Hold the response side while requests keep coming
    task automatic test_output_backpressure();
        rsp_hold_request = 300;
        repeat (20) send_item(random_request());
        wait_drain();
    endtask

    // Response side: random stalls plus an occasional long hold
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rsp_hold_request != 0)
            begin
                hold_left = rsp_hold_request;
                rsp_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= !(rsp_idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    task automatic report_mismatch(string field, logic [TIME_W-1:0] want,
                                   logic [TIME_W-1:0] got);
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
        mismatch_count++;
    endtask

    // Compare each response transaction with the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected response: expected none, actual %p", $time, rsp);
                mismatch_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.kind !== want.kind)
                    report_mismatch("kind", TIME_W'(want.kind), TIME_W'(rsp.kind));
                if (rsp.task_handle !== want.task_handle)
                    report_mismatch("task_handle", TIME_W'(want.task_handle),
                                    TIME_W'(rsp.task_handle));
                if (rsp.tag_out !== want.tag_out)
                    report_mismatch("tag_out", TIME_W'(want.tag_out), TIME_W'(rsp.tag_out));
                if (rsp.time_now !== want.time_now)
                    report_mismatch("time_now", want.time_now, rsp.time_now);
                if (rsp.last !== want.last)
                    report_mismatch("last", TIME_W'(want.last), TIME_W'(rsp.last));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        req_valid        = 1'b0;
        req              = '0;
        mismatch_count   = 0;
        rsp_hold_request = 0;
        req_idle_on      = 1'b1;
        rsp_idle_on      = 1'b1;
        timer_now        = '0;
        order_len        = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_armed[i] = 1'b0;
            slot_taken[i] = 1'b0;
        end
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_traffic(220);
        test_back_to_back(100);
        test_output_backpressure();
        test_random_traffic(130);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/swtt_pkg.sv
hw/rtl/swtt_ram.sv
hw/rtl/swtt_dp.sv
hw/rtl/swtt_ctrl.sv
hw/rtl/software_timer_table.sv
hw/rtl/swtt_checker.sv
tb/software_timer_table_test.sv
